// ===== rtl/tsw_pkg.sv =====
// Types, widths and helpers for the triangle stretch W kernel.
package tsw_pkg;

	localparam int unsigned FW = 32;          // Q16.16 field width
	localparam int unsigned MW = 64;          // magnitude width of D and numerators
	localparam int unsigned QW = 33;          // quotient bits kept before saturation
	localparam int unsigned DW = MW + 34;     // dividend width (num << 32, plus round bit)
	localparam int unsigned NQ = 10;          // quotients per triangle

	typedef struct packed {
		logic signed [FW-1:0] edge1_x;
		logic signed [FW-1:0] edge1_y;
		logic signed [FW-1:0] edge1_z;
		logic signed [FW-1:0] edge2_x;
		logic signed [FW-1:0] edge2_y;
		logic signed [FW-1:0] edge2_z;
		logic signed [FW-1:0] du_first;
		logic signed [FW-1:0] du_second;
		logic signed [FW-1:0] dv_first;
		logic signed [FW-1:0] dv_second;
	} tri_in_t;

	typedef struct packed {
		logic signed [FW-1:0] wu_x;
		logic signed [FW-1:0] wu_y;
		logic signed [FW-1:0] wu_z;
		logic signed [FW-1:0] wv_x;
		logic signed [FW-1:0] wv_y;
		logic signed [FW-1:0] wv_z;
		logic signed [FW-1:0] dwu_vertex1;
		logic signed [FW-1:0] dwu_vertex2;
		logic signed [FW-1:0] dwv_vertex1;
		logic signed [FW-1:0] dwv_vertex2;
		logic                 singular;
		logic                 saturated;
	} tri_out_t;

	// one signed-magnitude division job riding down the divider pipe
	typedef struct packed {
		logic          neg;
		logic          zero;
		logic [DW-1:0] num;   // remaining dividend bits, MSB first
		logic [MW:0]   rem;
		logic [QW-1:0] quo;
	} div_lane_t;

endpackage

// ===== rtl/triangle_stretch_w_kernel.sv =====
// Top level: pipelined stretch W matrix kernel for one cloth triangle per beat.
// Pipeline: three arithmetic stages, the divider stages and the output register.
// Throughput: one triangle per cycle unless out_ready stalls; every stage shares one enable.
// The long division is a chain of DIV_STAGES register stages of shared-width step logic.
// Reset: arst_n clears all valid bits asynchronously; payload registers are not reset.
module triangle_stretch_w_kernel #(
	parameter int unsigned DIV_STAGES = 33
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tsw_pkg::tri_in_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tsw_pkg::tri_out_t  out_data
);

	localparam int unsigned MW = tsw_pkg::MW;
	localparam int unsigned DW = tsw_pkg::DW;
	localparam int unsigned NQ = tsw_pkg::NQ;
	localparam int unsigned STEPS = (DW + DIV_STAGES - 1) / DIV_STAGES;
	localparam int unsigned NPIPE = DIV_STAGES + 4;

	logic en;
	logic [NPIPE-1:0] vld_q;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	// stage 1: products
	logic signed [63:0] p_det_a_s1, p_det_b_s1;
	logic signed [63:0] p_wu_a_s1 [3], p_wu_b_s1 [3], p_wv_a_s1 [3], p_wv_b_s1 [3];
	logic signed [31:0] du1_s1, du2_s1, dv1_s1, dv2_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_det_a_s1 <= 64'(in_data.du_first) * 64'(in_data.dv_second);
			p_det_b_s1 <= 64'(in_data.du_second) * 64'(in_data.dv_first);
			p_wu_a_s1[0] <= 64'(in_data.edge1_x) * 64'(in_data.dv_second);
			p_wu_a_s1[1] <= 64'(in_data.edge1_y) * 64'(in_data.dv_second);
			p_wu_a_s1[2] <= 64'(in_data.edge1_z) * 64'(in_data.dv_second);
			p_wu_b_s1[0] <= 64'(in_data.edge2_x) * 64'(in_data.dv_first);
			p_wu_b_s1[1] <= 64'(in_data.edge2_y) * 64'(in_data.dv_first);
			p_wu_b_s1[2] <= 64'(in_data.edge2_z) * 64'(in_data.dv_first);
			p_wv_a_s1[0] <= 64'(in_data.edge2_x) * 64'(in_data.du_first);
			p_wv_a_s1[1] <= 64'(in_data.edge2_y) * 64'(in_data.du_first);
			p_wv_a_s1[2] <= 64'(in_data.edge2_z) * 64'(in_data.du_first);
			p_wv_b_s1[0] <= 64'(in_data.edge1_x) * 64'(in_data.du_second);
			p_wv_b_s1[1] <= 64'(in_data.edge1_y) * 64'(in_data.du_second);
			p_wv_b_s1[2] <= 64'(in_data.edge1_z) * 64'(in_data.du_second);
			du1_s1 <= in_data.du_first;
			du2_s1 <= in_data.du_second;
			dv1_s1 <= in_data.dv_first;
			dv2_s1 <= in_data.dv_second;
		end
	end

	// stage 2: exact 65-bit differences
	logic signed [64:0] det_s2;
	logic signed [64:0] n_s2 [NQ];

	always_ff @(posedge clk) begin
		if (en) begin
			det_s2 <= 65'(p_det_a_s1) - 65'(p_det_b_s1);
			for (int c = 0; c < 3; c++) begin
				n_s2[c]     <= 65'(p_wu_a_s1[c]) - 65'(p_wu_b_s1[c]);
				n_s2[3 + c] <= 65'(p_wv_a_s1[c]) - 65'(p_wv_b_s1[c]);
			end
			n_s2[6] <= 65'(dv2_s1);
			n_s2[7] <= -65'(dv1_s1);
			n_s2[8] <= -65'(du2_s1);
			n_s2[9] <= 65'(du1_s1);
		end
	end

	// stage 3: magnitudes, dividends num*2^(shift+1) + |D|, divisor 2|D|
	tsw_pkg::div_lane_t [NQ-1:0] lane_s3;
	logic [MW:0] den2_s3;
	logic sing_s3;
	logic [MW-1:0] dmag;
	logic [MW-1:0] nmag [NQ];

	always_comb begin
		dmag = det_s2[64] ? MW'(-det_s2) : MW'(det_s2);
		for (int l = 0; l < NQ; l++)
			nmag[l] = n_s2[l][64] ? MW'(-n_s2[l]) : MW'(n_s2[l]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den2_s3 <= {dmag, 1'b0};
			sing_s3 <= (dmag == '0);
			for (int l = 0; l < NQ; l++) begin
				lane_s3[l].neg  <= n_s2[l][64] ^ det_s2[64];
				lane_s3[l].zero <= (nmag[l] == '0);
				lane_s3[l].rem  <= '0;
				lane_s3[l].quo  <= '0;
				if (l < 6)
					lane_s3[l].num <= DW'({nmag[l], 17'b0}) + DW'(dmag);
				else
					lane_s3[l].num <= DW'({nmag[l], 33'b0}) + DW'(dmag);
			end
		end
	end

	// divider pipe
	tsw_pkg::div_lane_t [NQ-1:0] dl [DIV_STAGES+1];
	logic [MW:0] den2_p [DIV_STAGES+1];
	logic sing_p [DIV_STAGES+1];

	assign dl[0] = lane_s3;
	assign den2_p[0] = den2_s3;
	assign sing_p[0] = sing_s3;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		localparam int unsigned LO = g * STEPS;
		localparam int unsigned NS = (LO >= DW) ? 1 : ((DW - LO < STEPS) ? DW - LO : STEPS);
		if (LO < DW) begin : g_act
			tsw_div_stage #(.STEPS(NS)) u_stage (
				.clk(clk), .en(en), .den2(den2_p[g]),
				.lane_in(dl[g]), .lane_out(dl[g+1])
			);
		end else begin : g_pass
			always_ff @(posedge clk) if (en) dl[g+1] <= dl[g];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den2_p[g+1] <= den2_p[g];
				sing_p[g+1] <= sing_p[g];
			end
		end
	end

	// final stage: sign, saturation, output register
	logic signed [31:0] res [NQ];
	logic [NQ-1:0] clip;
	tsw_pkg::tri_out_t out_nxt;

	always_comb begin
		for (int l = 0; l < NQ; l++) begin
			logic [tsw_pkg::QW-1:0] q;
			q = dl[DIV_STAGES][l].quo;
			clip[l] = 1'b0;
			res[l] = '0;
			if (!dl[DIV_STAGES][l].zero) begin
				if (dl[DIV_STAGES][l].neg) begin
					if (q > 33'h080000000) begin
						clip[l] = 1'b1;
						res[l] = 32'sh80000000;
					end else begin
						res[l] = -32'(q);
					end
				end else if (q > 33'h07FFFFFFF) begin
					clip[l] = 1'b1;
					res[l] = 32'sh7FFFFFFF;
				end else begin
					res[l] = 32'(q);
				end
			end
		end
	end

	always_comb begin
		out_nxt = '0;
		if (sing_p[DIV_STAGES]) begin
			out_nxt.singular = 1'b1;
		end else begin
			out_nxt.wu_x = res[0];
			out_nxt.wu_y = res[1];
			out_nxt.wu_z = res[2];
			out_nxt.wv_x = res[3];
			out_nxt.wv_y = res[4];
			out_nxt.wv_z = res[5];
			out_nxt.dwu_vertex1 = res[6];
			out_nxt.dwu_vertex2 = res[7];
			out_nxt.dwv_vertex1 = res[8];
			out_nxt.dwv_vertex2 = res[9];
			out_nxt.saturated = |clip;
		end
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= out_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NPIPE-2:0], in_valid};
		end
	end

	assign out_valid = vld_q[NPIPE-1];

endmodule

// ===== rtl/tsw_div_stage.sv =====
// One pipelined block of restoring-division steps for all quotient lanes.
module tsw_div_stage #(
	parameter int unsigned STEPS = 4
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [tsw_pkg::MW:0]                   den2,
	input  tsw_pkg::div_lane_t [tsw_pkg::NQ-1:0]   lane_in,
	output tsw_pkg::div_lane_t [tsw_pkg::NQ-1:0]   lane_out
);

	tsw_pkg::div_lane_t [tsw_pkg::NQ-1:0] nxt;

	always_comb begin
		nxt = lane_in;
		for (int l = 0; l < tsw_pkg::NQ; l++) begin
			for (int s = 0; s < STEPS; s++) begin
				logic [tsw_pkg::MW+1:0] r;
				logic top;
				top = nxt[l].quo[tsw_pkg::QW-1];
				r = {nxt[l].rem, nxt[l].num[tsw_pkg::DW-1]};
				nxt[l].num = {nxt[l].num[tsw_pkg::DW-2:0], 1'b0};
				if (r >= {1'b0, den2}) begin
					r = r - {1'b0, den2};
					nxt[l].quo = {nxt[l].quo[tsw_pkg::QW-2:0], 1'b1};
				end else begin
					nxt[l].quo = {nxt[l].quo[tsw_pkg::QW-2:0], 1'b0};
				end
				// quotient overflow is sticky in the top bit
				nxt[l].quo[tsw_pkg::QW-1] = nxt[l].quo[tsw_pkg::QW-1] | top;
				nxt[l].rem = r[tsw_pkg::MW:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) lane_out <= nxt;
	end

endmodule

// ===== rtl/tsw_checker.sv =====
// Port-level checks for the triangle stretch W kernel, bound to the top level.
module tsw_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input tsw_pkg::tri_out_t out_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.singular |-> !out_data.saturated && out_data.wu_x == 0
			&& out_data.dwv_vertex2 == 0)
		else $error("singular beat carries data");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipe stalled");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("input beat withdrawn before accept");

endmodule

bind triangle_stretch_w_kernel tsw_checker u_tsw_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
